/* rtl/dfcs_pkg.sv */
// ----------------------------------------------------------------------------
// dfcs_pkg - shared types and constants of the focus candidate selector
// Coordinate and identifier widths, derived datapath widths, direction and
// register codes, and the classified item that goes from front to back.
// ----------------------------------------------------------------------------
package dfcs_pkg;

  // Field widths
  localparam int COORD_BITS = 16;
  localparam int ID_BITS    = 16;

  // Derived widths
  localparam int CW  = COORD_BITS;      // signed corner coordinate
  localparam int SW  = COORD_BITS - 1;  // unsigned size
  localparam int EW  = COORD_BITS + 2;  // signed edge, also holds an edge difference
  localparam int CSW = COORD_BITS + 3;  // signed difference of doubled centers
  localparam int GW  = COORD_BITS + 1;  // unsigned gap or half center distance
  localparam int QW  = 2 * GW;          // square of a gap
  localparam int WW  = 2 * GW + 5;      // 13*major^2 + minor^2

  // Queue between front and back (depth a power of two)
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Configuration port
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIRECTION     = 3'd0,
    CFG_SOURCE_X      = 3'd1,
    CFG_SOURCE_Y      = 3'd2,
    CFG_SOURCE_WIDTH  = 3'd3,
    CFG_SOURCE_HEIGHT = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_t;

  // Classified candidate
  typedef struct packed {
    logic               ok;     // lies in the search direction
    logic               ovl;    // overlaps the source beam
    logic               tow;    // fully beyond the source edge
    logic               horiz;  // left or right search
    logic [GW-1:0]      near;   // major distance, clamped at zero
    logic [GW-1:0]      far;    // far-edge distance, clamped at one
    logic [GW-1:0]      side;   // minor distance
    logic [ID_BITS-1:0] id;
    logic               last;
  } item_t;

  // Sign-extend a corner coordinate to edge width
  function automatic logic signed [EW-1:0] edge_of(input logic [CW-1:0] v);
    return {{(EW-CW){v[CW-1]}}, v};
  endfunction

  // Zero-extend a size to edge width
  function automatic logic signed [EW-1:0] size_of(input logic [SW-1:0] v);
    return {{(EW-SW){1'b0}}, v};
  endfunction

endpackage

/* rtl/dfcs_front.sv */
// ----------------------------------------------------------------------------
// dfcs_front - configuration registers and candidate classifier
// Holds the source rectangle and direction, and turns each incoming
// candidate into direction flags and distances for the back end.
// ----------------------------------------------------------------------------
module dfcs_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [dfcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dfcs_pkg::CW-1:0]      cfg_wdata,
  input  logic [dfcs_pkg::CW-1:0]      cand_x,
  input  logic [dfcs_pkg::CW-1:0]      cand_y,
  input  logic [dfcs_pkg::SW-1:0]      cand_width,
  input  logic [dfcs_pkg::SW-1:0]      cand_height,
  input  logic [dfcs_pkg::ID_BITS-1:0] cand_id,
  input  logic                         is_last,
  output dfcs_pkg::item_t              item,
  output logic                         restart
);
  import dfcs_pkg::*;

  dir_t          dir_r, dir_nxt;
  logic [CW-1:0] src_x_r, src_x_nxt;
  logic [CW-1:0] src_y_r, src_y_nxt;
  logic [SW-1:0] src_w_r, src_w_nxt;
  logic [SW-1:0] src_h_r, src_h_nxt;
  logic          cfg_hit;

  logic signed [EW-1:0]  s_l, s_t, s_r, s_b;
  logic signed [EW-1:0]  c_l, c_t, c_r, c_b;
  logic signed [EW-1:0]  near_d, far_d;
  logic signed [CSW-1:0] side_d, side_abs;
  logic                  horiz;
  logic                  cand_ok, cand_tow, cand_ovl;
  logic [GW-1:0]         near_clamp, far_clamp;

  assign cfg_ready = 1'b1;

  // Decode register writes; any known register restarts the search
  always_comb begin
    dir_nxt   = dir_r;
    src_x_nxt = src_x_r;
    src_y_nxt = src_y_r;
    src_w_nxt = src_w_r;
    src_h_nxt = src_h_r;
    cfg_hit   = 1'b0;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_DIRECTION: begin
          dir_nxt = dir_t'(cfg_wdata[1:0]);
          cfg_hit = 1'b1;
        end
        CFG_SOURCE_X: begin
          src_x_nxt = cfg_wdata;
          cfg_hit   = 1'b1;
        end
        CFG_SOURCE_Y: begin
          src_y_nxt = cfg_wdata;
          cfg_hit   = 1'b1;
        end
        CFG_SOURCE_WIDTH: begin
          src_w_nxt = cfg_wdata[SW-1:0];
          cfg_hit   = 1'b1;
        end
        CFG_SOURCE_HEIGHT: begin
          src_h_nxt = cfg_wdata[SW-1:0];
          cfg_hit   = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  assign restart = cfg_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r   <= DIR_LEFT;
      src_x_r <= '0;
      src_y_r <= '0;
      src_w_r <= '0;
      src_h_r <= '0;
    end else begin
      dir_r   <= dir_nxt;
      src_x_r <= src_x_nxt;
      src_y_r <= src_y_nxt;
      src_w_r <= src_w_nxt;
      src_h_r <= src_h_nxt;
    end
  end

  // Rectangle edges
  assign s_l = edge_of(src_x_r);
  assign s_t = edge_of(src_y_r);
  assign s_r = s_l + size_of(src_w_r);
  assign s_b = s_t + size_of(src_h_r);
  assign c_l = edge_of(cand_x);
  assign c_t = edge_of(cand_y);
  assign c_r = c_l + size_of(cand_width);
  assign c_b = c_t + size_of(cand_height);

  assign horiz = (dir_r == DIR_LEFT) || (dir_r == DIR_RIGHT);

  // Classify against the source per direction
  always_comb begin
    cand_ok  = 1'b0;
    cand_tow = 1'b0;
    near_d   = '0;
    far_d    = '0;
    case (dir_r)
      DIR_LEFT: begin
        cand_ok  = ((s_r > c_r) || (s_l >= c_r)) && (s_l > c_l);
        cand_tow = (s_l >= c_r);
        near_d   = s_l - c_r;
        far_d    = s_l - c_l;
      end
      DIR_RIGHT: begin
        cand_ok  = ((s_l < c_l) || (s_r <= c_l)) && (s_r < c_r);
        cand_tow = (s_r <= c_l);
        near_d   = c_l - s_r;
        far_d    = c_r - s_r;
      end
      DIR_UP: begin
        cand_ok  = ((s_b > c_b) || (s_t >= c_b)) && (s_t > c_t);
        cand_tow = (s_t >= c_b);
        near_d   = s_t - c_b;
        far_d    = s_t - c_t;
      end
      DIR_DOWN: begin
        cand_ok  = ((s_t < c_t) || (s_b <= c_t)) && (s_b < c_b);
        cand_tow = (s_b <= c_t);
        near_d   = c_t - s_b;
        far_d    = c_b - s_b;
      end
      default: begin
        cand_ok  = 1'b0;
        cand_tow = 1'b0;
      end
    endcase
  end

  // Beam overlap on the minor axis
  assign cand_ovl = horiz ? ((c_b >= s_t) && (c_t <= s_b))
                          : ((c_r >= s_l) && (c_l <= s_r));

  // Minor distance: half the absolute difference of the center sums
  assign side_d = horiz
    ? (CSW'(s_t) + CSW'(s_b)) - (CSW'(c_t) + CSW'(c_b))
    : (CSW'(s_l) + CSW'(s_r)) - (CSW'(c_l) + CSW'(c_r));
  assign side_abs = (side_d < 0) ? -side_d : side_d;

  // Clamp the gaps
  assign near_clamp = (near_d < 0) ? '0 : near_d[GW-1:0];
  assign far_clamp  = (far_d < 1) ? GW'(1) : far_d[GW-1:0];

  // Pack the item in field order: ok, ovl, tow, horiz, near, far, side, id, last
  assign item = {cand_ok, cand_ovl, cand_tow, horiz, near_clamp, far_clamp,
                 side_abs[GW:1], cand_id, is_last};

endmodule

/* rtl/dfcs_queue.sv */
// ----------------------------------------------------------------------------
// dfcs_queue - two-entry queue of classified items
// Decouples the classifier from the compare unit so each side stalls alone.
// ----------------------------------------------------------------------------
module dfcs_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  dfcs_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output dfcs_pkg::item_t pop_item,
  output logic            empty
);
  import dfcs_pkg::*;

  item_t          mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic           push_ok, pop_ok;

  assign full     = (cnt_r == QCW'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign push_ok  = push && !full;
  assign pop_ok   = pop && !empty;
  assign pop_item = mem_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = push_ok ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCW'(QDEPTH))
    else $error("queue count beyond depth");

  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push_ok && !pop_ok) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count missed a push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == QCW'(1)) |-> (wr_ptr_r != rd_ptr_r))
    else $error("queue pointers disagree with count");

endmodule

/* rtl/dfcs_back.sv */
// ----------------------------------------------------------------------------
// dfcs_back - compare unit and result register
// Squares the distances of one item, then compares it with the kept best,
// updates the best and, on the last item, loads the result register.
// ----------------------------------------------------------------------------
module dfcs_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         restart,
  input  logic                         q_empty,
  input  dfcs_pkg::item_t              q_item,
  output logic                         q_pop,
  output logic                         res_empty,
  input  logic                         res_pop,
  output logic [dfcs_pkg::ID_BITS-1:0] res_best_id,
  output logic                         res_found
);
  import dfcs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_CMP
  } state_t;

  state_t             st_r, st_nxt;
  item_t              item_r, item_nxt;
  logic [QW-1:0]      sq_near_r, sq_near_nxt;
  logic [QW-1:0]      sq_side_r, sq_side_nxt;

  // Kept best, as seen from the source
  logic               have_r, have_nxt;
  logic [ID_BITS-1:0] ident_r, ident_nxt;
  logic               k_ovl_r, k_ovl_nxt;
  logic               k_tow_r, k_tow_nxt;
  logic [GW-1:0]      k_near_r, k_near_nxt;
  logic [GW-1:0]      k_far_r, k_far_nxt;
  logic [WW-1:0]      k_w_r, k_w_nxt;

  logic               res_valid_r, res_valid_nxt;
  logic [ID_BITS-1:0] res_id_r, res_id_nxt;
  logic               res_found_r, res_found_nxt;

  logic               take, commit, res_free;
  logic               beam_c, beam_k, win;
  logic [WW-1:0]      w_cand;

  assign res_free = !res_valid_r || res_pop;

  // Sequence one item: load, square, compare
  always_comb begin
    st_nxt = st_r;
    take   = 1'b0;
    commit = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (!q_empty) begin
          take   = 1'b1;
          st_nxt = ST_MUL;
        end
      end
      ST_MUL: st_nxt = ST_CMP;
      ST_CMP: begin
        if (!item_r.last || res_free) begin
          commit = 1'b1;
          if (!q_empty) begin
            take   = 1'b1;
            st_nxt = ST_MUL;
          end else begin
            st_nxt = ST_IDLE;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign q_pop    = take;
  assign item_nxt = take ? q_item : item_r;

  // Square the major and minor distances
  assign sq_near_nxt = (st_r == ST_MUL) ? QW'(item_r.near) * QW'(item_r.near) : sq_near_r;
  assign sq_side_nxt = (st_r == ST_MUL) ? QW'(item_r.side) * QW'(item_r.side) : sq_side_r;

  // Weighted distance: 13*major^2 + minor^2
  assign w_cand = (WW'(sq_near_r) << 3) + (WW'(sq_near_r) << 2) + WW'(sq_near_r)
                + WW'(sq_side_r);

  // Beam rule both ways, then the weight
  assign beam_c = !k_ovl_r && item_r.ovl
               && (!k_tow_r || item_r.horiz || (item_r.near < k_far_r));
  assign beam_k = !item_r.ovl && k_ovl_r
               && (!item_r.tow || item_r.horiz || (k_near_r < item_r.far));
  assign win = item_r.ok && (!have_r || beam_c || (!beam_k && (w_cand < k_w_r)));

  // Update the kept best and the result
  always_comb begin
    have_nxt      = have_r;
    ident_nxt     = ident_r;
    k_ovl_nxt     = k_ovl_r;
    k_tow_nxt     = k_tow_r;
    k_near_nxt    = k_near_r;
    k_far_nxt     = k_far_r;
    k_w_nxt       = k_w_r;
    res_valid_nxt = res_valid_r && !res_pop;
    res_id_nxt    = res_id_r;
    res_found_nxt = res_found_r;
    if (commit) begin
      if (win) begin
        have_nxt   = 1'b1;
        ident_nxt  = item_r.id;
        k_ovl_nxt  = item_r.ovl;
        k_tow_nxt  = item_r.tow;
        k_near_nxt = item_r.near;
        k_far_nxt  = item_r.far;
        k_w_nxt    = w_cand;
      end
      if (item_r.last) begin
        res_valid_nxt = 1'b1;
        res_found_nxt = have_nxt;
        res_id_nxt    = have_nxt ? ident_nxt : '0;
        have_nxt      = 1'b0;
        ident_nxt     = '0;
      end
    end
    if (restart) begin
      have_nxt  = 1'b0;
      ident_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    sq_near_r <= sq_near_nxt;
    sq_side_r <= sq_side_nxt;
    k_ovl_r   <= k_ovl_nxt;
    k_tow_r   <= k_tow_nxt;
    k_near_r  <= k_near_nxt;
    k_far_r   <= k_far_nxt;
    k_w_r     <= k_w_nxt;
    res_id_r  <= res_id_nxt;
    res_found_r <= res_found_nxt;
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      have_r      <= 1'b0;
      ident_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      have_r      <= have_nxt;
      ident_r     <= ident_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  assign res_empty   = !res_valid_r;
  assign res_best_id = res_id_r;
  assign res_found   = res_found_r;

  a_mul_then_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_MUL) |=> (st_r == ST_CMP))
    else $error("square stage not followed by compare");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && !res_pop) |=> (res_valid_r && $stable(res_id_r)
                                   && $stable(res_found_r)))
    else $error("waiting result overwritten");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && !res_found_r) |-> (res_id_r == '0))
    else $error("result without winner carries an identifier");

  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && item_r.last) |=> !have_r)
    else $error("search not restarted after last item");

endmodule

/* rtl/directional_focus_candidate_select.sv */
// ----------------------------------------------------------------------------
// directional_focus_candidate_select - directional focus candidate selector
// Keeps the best rectangle in one direction away from a source rectangle
// over a stream of candidates and reports the winner on the last one.
// ----------------------------------------------------------------------------
//
//   channel   handshake            payload
//   in_       in_push / in_full    cand_x, cand_y, cand_width, cand_height,
//                                  cand_id, is_last
//   out_      out_pop / out_empty  best_id, found
//   cfg_      cfg_valid/cfg_ready  cfg_index, cfg_wdata
//
// The classifier takes one item a cycle into a two-entry queue while the
// queue is not full. The compare unit handles each item in state ST_MUL,
// which squares the distances, and then ST_CMP, which weighs and compares
// against the kept best and loads the next queued item, if any, as it commits.
// Reset has no clearing pass. A last item waits in the compare stage while
// an earlier result is still unread; the queue then fills and in_full rises.
// ----------------------------------------------------------------------------
module directional_focus_candidate_select (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [dfcs_pkg::CW-1:0]        in_cand_x,
  input  logic [dfcs_pkg::CW-1:0]        in_cand_y,
  input  logic [dfcs_pkg::SW-1:0]        in_cand_width,
  input  logic [dfcs_pkg::SW-1:0]        in_cand_height,
  input  logic [dfcs_pkg::ID_BITS-1:0]   in_cand_id,
  input  logic                           in_is_last,
  input  logic                           out_pop,
  output logic                           out_empty,
  output logic [dfcs_pkg::ID_BITS-1:0]   out_best_id,
  output logic                           out_found,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dfcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dfcs_pkg::CW-1:0]        cfg_wdata
);
  import dfcs_pkg::*;

  item_t front_item;
  item_t q_item;
  logic  restart;
  logic  q_full, q_empty, q_pop;

  // Classify and hold configuration
  dfcs_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .cand_x      (in_cand_x),
    .cand_y      (in_cand_y),
    .cand_width  (in_cand_width),
    .cand_height (in_cand_height),
    .cand_id     (in_cand_id),
    .is_last     (in_is_last),
    .item        (front_item),
    .restart     (restart)
  );

  // Buffer classified items
  dfcs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_item),
    .empty     (q_empty)
  );

  assign in_full = q_full;

  // Compare against the kept best and report
  dfcs_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .restart     (restart),
    .q_empty     (q_empty),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .res_empty   (out_empty),
    .res_pop     (out_pop),
    .res_best_id (out_best_id),
    .res_found   (out_found)
  );

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - directional focus candidate selector testbench
// Streams candidate rectangles through the selector under several source
// rectangles and search directions, predicts the reported winner with an
// in-bench scoring model, and checks every result item field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import dfcs_pkg::*;

  localparam int     HALF_PERIOD   = 4;
  localparam int     RESET_CYCLES  = 5;
  localparam int     SETTLE_CYCLES = 20;
  localparam int     RANDOM_ITEMS  = 400;
  localparam int     TIMEOUT_NS    = 3_000_000;
  localparam longint MAJOR_WEIGHT  = 13;
  localparam int     COORD_MIN     = -(1 << (CW - 1));
  localparam int     COORD_MAX     = (1 << (CW - 1)) - 1;
  localparam int     SIZE_MAX      = (1 << SW) - 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_CODE    = '1;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [SW-1:0]        w;
    logic [SW-1:0]        h;
    logic [ID_BITS-1:0]   id;
    logic                 last;
  } cand_t;

  typedef struct {
    logic [ID_BITS-1:0] best_id;
    logic               found;
  } verdict_t;

  typedef struct {
    longint l;
    longint t;
    longint r;
    longint b;
  } rect_t;

  // Block ports
  logic                 clk;
  logic                 rst_n          = 1'b0;
  logic                 in_push        = 1'b0;
  logic                 in_full;
  logic [CW-1:0]        in_cand_x      = '0;
  logic [CW-1:0]        in_cand_y      = '0;
  logic [SW-1:0]        in_cand_width  = '0;
  logic [SW-1:0]        in_cand_height = '0;
  logic [ID_BITS-1:0]   in_cand_id     = '0;
  logic                 in_is_last     = 1'b0;
  logic                 out_pop        = 1'b0;
  logic                 out_empty;
  logic [ID_BITS-1:0]   out_best_id;
  logic                 out_found;
  logic                 cfg_valid      = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index      = '0;
  logic [CW-1:0]        cfg_wdata      = '0;

  // Stimulus and scoreboard state
  cand_t    pending[$];
  verdict_t results_due[$];
  cand_t    drv_item;
  bit       drv_busy    = 1'b0;
  bit       idle_on     = 1'b1;
  int       in_gap      = 0;
  int       pop_gap     = 0;
  int       error_count = 0;

  // Mirrored configuration and kept best rectangle
  dir_t                 src_dir;
  logic signed [CW-1:0] src_x;
  logic signed [CW-1:0] src_y;
  logic [SW-1:0]        src_w;
  logic [SW-1:0]        src_h;
  longint               keep_left;
  longint               keep_top;
  longint               keep_w;
  longint               keep_h;
  logic [ID_BITS-1:0]   keep_id;
  bit                   keep_valid;

  directional_focus_candidate_select dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_cand_x      (in_cand_x),
    .in_cand_y      (in_cand_y),
    .in_cand_width  (in_cand_width),
    .in_cand_height (in_cand_height),
    .in_cand_id     (in_cand_id),
    .in_is_last     (in_is_last),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_best_id    (out_best_id),
    .out_found      (out_found),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #HALF_PERIOD;
    clk = 1'b1;
    #HALF_PERIOD;
  end

  // ---------------------------------------------------------------------------
  // Scoring model
  // ---------------------------------------------------------------------------
  function automatic rect_t make_rect(longint x, longint y, longint w, longint h);
    rect_t b;
    b.l = x;
    b.t = y;
    b.r = x + w;
    b.b = y + h;
    return b;
  endfunction

  function automatic bit horizontal(dir_t d);
    return d == DIR_LEFT || d == DIR_RIGHT;
  endfunction

  // Candidate lies in the search direction from the source
  function automatic bit in_direction(dir_t d, rect_t s, rect_t c);
    case (d)
      DIR_LEFT:  return (s.r > c.r || s.l >= c.r) && s.l > c.l;
      DIR_RIGHT: return (s.l < c.l || s.r <= c.l) && s.r < c.r;
      DIR_UP:    return (s.b > c.b || s.t >= c.b) && s.t > c.t;
      default:   return (s.t < c.t || s.b <= c.t) && s.b < c.b;
    endcase
  endfunction

  // Candidate is entirely past the source's leading edge
  function automatic bit fully_beyond(dir_t d, rect_t s, rect_t c);
    case (d)
      DIR_LEFT:  return s.l >= c.r;
      DIR_RIGHT: return s.r <= c.l;
      DIR_UP:    return s.t >= c.b;
      default:   return s.b <= c.t;
    endcase
  endfunction

  function automatic bit in_beam(dir_t d, rect_t s, rect_t c);
    if (horizontal(d)) return c.b >= s.t && c.t <= s.b;
    return c.r >= s.l && c.l <= s.r;
  endfunction

  function automatic longint major_gap(dir_t d, rect_t s, rect_t c);
    longint v;
    case (d)
      DIR_LEFT:  v = s.l - c.r;
      DIR_RIGHT: v = c.l - s.r;
      DIR_UP:    v = s.t - c.b;
      default:   v = c.t - s.b;
    endcase
    return (v < 0) ? 0 : v;
  endfunction

  function automatic longint far_gap(dir_t d, rect_t s, rect_t c);
    longint v;
    case (d)
      DIR_LEFT:  v = s.l - c.l;
      DIR_RIGHT: v = c.r - s.r;
      DIR_UP:    v = s.t - c.t;
      default:   v = c.b - s.b;
    endcase
    return (v < 1) ? 1 : v;
  endfunction

  // Half the distance between doubled centers, truncated
  function automatic longint minor_gap(dir_t d, rect_t s, rect_t c);
    longint v;
    if (horizontal(d)) v = (s.t + s.b) - (c.t + c.b);
    else v = (s.l + s.r) - (c.l + c.r);
    if (v < 0) v = -v;
    return v / 2;
  endfunction

  // True when the beam rule alone favors a over c
  function automatic bit beam_preferred(dir_t d, rect_t s, rect_t a, rect_t c);
    if (in_beam(d, s, c) || !in_beam(d, s, a)) return 1'b0;
    if (!fully_beyond(d, s, c)) return 1'b1;
    if (horizontal(d)) return 1'b1;
    return major_gap(d, s, a) < far_gap(d, s, c);
  endfunction

  function automatic longint focus_score(dir_t d, rect_t s, rect_t c);
    longint mj;
    longint mn;
    mj = major_gap(d, s, c);
    mn = minor_gap(d, s, c);
    return MAJOR_WEIGHT * mj * mj + mn * mn;
  endfunction

  // Put the kept best back on the source, shifted one against the direction
  task automatic restart_search();
    keep_left = longint'(src_x);
    keep_top  = longint'(src_y);
    case (src_dir)
      DIR_LEFT:  keep_left = keep_left + 1;
      DIR_RIGHT: keep_left = keep_left - 1;
      DIR_UP:    keep_top  = keep_top + 1;
      default:   keep_top  = keep_top - 1;
    endcase
    keep_w     = longint'(src_w);
    keep_h     = longint'(src_h);
    keep_id    = '0;
    keep_valid = 1'b0;
  endtask

  task automatic apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] data);
    case (idx)
      CFG_DIRECTION:     src_dir = dir_t'(data[1:0]);
      CFG_SOURCE_X:      src_x   = data;
      CFG_SOURCE_Y:      src_y   = data;
      CFG_SOURCE_WIDTH:  src_w   = data[SW-1:0];
      CFG_SOURCE_HEIGHT: src_h   = data[SW-1:0];
      default:           return;
    endcase
    restart_search();
  endtask

  // Fold one candidate into the kept best; queue the verdict on a last item
  task automatic predict_candidate(cand_t c);
    rect_t    s;
    rect_t    n;
    rect_t    k;
    bit       win;
    verdict_t v;
    s = make_rect(longint'(src_x), longint'(src_y), longint'(src_w), longint'(src_h));
    n = make_rect(longint'(c.x), longint'(c.y), longint'(c.w), longint'(c.h));
    k = make_rect(keep_left, keep_top, keep_w, keep_h);
    if (!in_direction(src_dir, s, n)) win = 1'b0;
    else if (!in_direction(src_dir, s, k)) win = 1'b1;
    else if (beam_preferred(src_dir, s, n, k)) win = 1'b1;
    else if (beam_preferred(src_dir, s, k, n)) win = 1'b0;
    else win = focus_score(src_dir, s, n) < focus_score(src_dir, s, k);
    if (win) begin
      keep_left  = longint'(c.x);
      keep_top   = longint'(c.y);
      keep_w     = longint'(c.w);
      keep_h     = longint'(c.h);
      keep_id    = c.id;
      keep_valid = 1'b1;
    end
    if (c.last) begin
      v.best_id = keep_valid ? keep_id : '0;
      v.found   = keep_valid;
      results_due.push_back(v);
      restart_search();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Handshake helpers
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string what);
    error_count++;
    $display("%0t: mismatch: %s", $time, what);
  endtask

  // Input side: hold the item until accepted, then load the next one
  always @(negedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (!drv_busy) begin
      if (in_gap > 0) begin
        in_gap--;
        in_push <= 1'b0;
      end else if (pending.size() != 0) begin
        drv_item = pending.pop_front();
        in_cand_x      <= drv_item.x;
        in_cand_y      <= drv_item.y;
        in_cand_width  <= drv_item.w;
        in_cand_height <= drv_item.h;
        in_cand_id     <= drv_item.id;
        in_is_last     <= drv_item.last;
        in_push        <= 1'b1;
        drv_busy = 1'b1;
        in_gap   = pick_gap();
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // Predict on every accepted item
  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) begin
      predict_candidate(drv_item);
      drv_busy = 1'b0;
    end
  end

  // Result side: pop with random stalls
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (pop_gap > 0) begin
      pop_gap--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
      if ($urandom_range(0, 2) == 0) pop_gap = pick_gap();
    end
  end

  // Compare each popped item against the oldest prediction
  always @(posedge clk) begin : check_results
    verdict_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("result best_id=%h found=%b with none expected",
                                  out_best_id, out_found));
      end else begin
        want = results_due.pop_front();
        if (out_best_id !== want.best_id)
          report_mismatch($sformatf("best_id got %h expected %h",
                                    out_best_id, want.best_id));
        if (out_found !== want.found)
          report_mismatch($sformatf("found got %b expected %b", out_found, want.found));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_item(int x, int y, int w, int h, int id, bit last);
    cand_t c;
    c.x    = CW'(x);
    c.y    = CW'(y);
    c.w    = SW'(w);
    c.h    = SW'(h);
    c.id   = ID_BITS'(id);
    c.last = last;
    pending.push_back(c);
  endtask

  // Wait for all items and results to drain, then let the pipeline empty
  task automatic settle();
    while (pending.size() != 0 || drv_busy || results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_cfg(idx, data);
  endtask

  task automatic cfg_release();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_source(dir_t d, int x, int y, int w, int h);
    cfg_write(CFG_DIRECTION, CW'(d));
    cfg_write(CFG_SOURCE_X, CW'(x));
    cfg_write(CFG_SOURCE_Y, CW'(y));
    cfg_write(CFG_SOURCE_WIDTH, CW'(w));
    cfg_write(CFG_SOURCE_HEIGHT, CW'(h));
    cfg_release();
  endtask

  function automatic logic [CW-1:0] pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return CW'(COORD_MIN);
    if (r == 1) return CW'(COORD_MAX);
    return CW'(int'($urandom_range(0, 2000)) - 1000);
  endfunction

  // Size with a random ignored top bit
  function automatic logic [CW-1:0] pick_size();
    logic [CW-1:0] v;
    int            r;
    r = $urandom_range(0, 9);
    if (r == 0) v = '0;
    else if (r == 1) v = CW'(SIZE_MAX);
    else v = CW'($urandom_range(0, 300));
    v[CW-1] = 1'($urandom_range(0, 1));
    return v;
  endfunction

  // Rewrite some or all registers, with an occasional write to an unused index
  task automatic reconfigure(bit all);
    logic [CW-1:0] dir_word;
    dir_word = CW'($urandom);
    if (all || $urandom_range(0, 9) < 7) cfg_write(CFG_DIRECTION, dir_word);
    if (all || $urandom_range(0, 9) < 7) cfg_write(CFG_SOURCE_X, pick_coord());
    if (all || $urandom_range(0, 9) < 7) cfg_write(CFG_SOURCE_Y, pick_coord());
    if (all || $urandom_range(0, 9) < 7) cfg_write(CFG_SOURCE_WIDTH, pick_size());
    if (all || $urandom_range(0, 9) < 7) cfg_write(CFG_SOURCE_HEIGHT, pick_size());
    if ($urandom_range(0, 4) == 0)
      cfg_write(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_CODE)),
                CW'($urandom));
    cfg_release();
  endtask

  function automatic int clamp_coord(int v);
    if (v < COORD_MIN) return COORD_MIN;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  // Mostly rectangles around the source, some full-range noise
  function automatic cand_t random_candidate();
    cand_t c;
    int    r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      c.x = CW'($urandom);
      c.y = CW'($urandom);
      c.w = SW'($urandom);
      c.h = SW'($urandom);
    end else begin
      c.x = CW'(clamp_coord(int'(src_x) - 300 + int'($urandom_range(0, int'(src_w) + 600))));
      c.y = CW'(clamp_coord(int'(src_y) - 300 + int'($urandom_range(0, int'(src_h) + 600))));
      c.w = (r < 20) ? SW'($urandom_range(0, SIZE_MAX)) : SW'($urandom_range(0, 150));
      c.h = (r < 20) ? SW'($urandom_range(0, SIZE_MAX)) : SW'($urandom_range(0, 150));
    end
    c.id   = ID_BITS'($urandom);
    c.last = 1'b0;
    return c;
  endfunction

  initial begin : stimulus
    cand_t c;
    cand_t prev;
    int    n_random;
    int    n_searches;
    int    run_len;
    bit    first;

    // Predictor starts from the register reset values
    src_dir = DIR_LEFT;
    src_x   = '0;
    src_y   = '0;
    src_w   = '0;
    src_h   = '0;
    restart_search();
    prev = random_candidate();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty source after reset: one candidate to the right, one to the left
    queue_item(100, 0, 10, 10, 'h1234, 1'b1);
    queue_item(-5, 0, 0, 0, 'h0001, 1'b1);
    settle();

    // Left search: far corner, beam winner, closer off-beam loser, nearer beam winner
    set_source(DIR_LEFT, 1000, 1000, 100, 100);
    queue_item(COORD_MIN, COORD_MIN, 0, 0, 'hFFFF, 1'b0);
    queue_item(800, 1000, 50, 50, 'h0001, 1'b0);
    queue_item(900, 2000, 50, 50, 'h0002, 1'b0);
    queue_item(850, 1020, 20, 20, 'h0003, 1'b1);
    settle();

    // Right search from a source at the far edge: nothing can qualify
    set_source(DIR_RIGHT, COORD_MAX, 0, SIZE_MAX, 0);
    queue_item(COORD_MAX, 0, SIZE_MAX, 0, 'h8000, 1'b0);
    queue_item(COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX, 'hFFFF, 1'b1);
    settle();

    // Up search with a tie: the earlier equal candidate stays
    set_source(DIR_UP, 0, COORD_MAX, SIZE_MAX, SIZE_MAX);
    queue_item(-100, 32000, 200, 100, 'h0010, 1'b0);
    queue_item(5000, 30000, 100, 100, 'h0011, 1'b0);
    queue_item(-100, 32000, 200, 100, 'h0012, 1'b1);
    settle();

    // Down search; a write to an unused index must not restart the search
    set_source(DIR_DOWN, COORD_MIN, COORD_MIN, 0, 0);
    queue_item(COORD_MIN, COORD_MIN, 0, 0, 'hAAAA, 1'b1);
    queue_item(-32000, 0, 10, 10, 'h5555, 1'b0);
    settle();
    cfg_write(CFG_FIRST_UNUSED, 16'hFFFF);
    cfg_release();
    queue_item(COORD_MIN, COORD_MAX, SIZE_MAX, SIZE_MAX, 'hFFFF, 1'b1);
    settle();

    // Random searches under changing sources
    n_random = 0;
    first    = 1'b1;
    while (n_random < RANDOM_ITEMS) begin
      idle_on = $urandom_range(0, 3) != 0;
      reconfigure(first);
      first      = 1'b0;
      n_searches = $urandom_range(2, 6);
      for (int s = 0; s < n_searches; s++) begin
        run_len = $urandom_range(1, 8);
        for (int i = 0; i < run_len; i++) begin
          // Repeat the previous rectangle now and then to hit ties
          if ($urandom_range(0, 9) == 0) begin
            c    = prev;
            c.id = ID_BITS'($urandom);
          end else begin
            c = random_candidate();
          end
          c.last = (i == run_len - 1);
          // Leave the final search open sometimes; the next write restarts it
          if (c.last && s == n_searches - 1 && $urandom_range(0, 9) == 0) c.last = 1'b0;
          pending.push_back(c);
          prev = c;
          n_random++;
        end
      end
      settle();
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #TIMEOUT_NS;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* sim.f */
rtl/dfcs_pkg.sv
rtl/dfcs_front.sv
rtl/dfcs_queue.sv
rtl/dfcs_back.sv
rtl/directional_focus_candidate_select.sv
tb/sv/tb_top.sv
